@@ sv/skl_pkg.sv @@
// Shared widths, defaults and controller command type for the k-th largest unit.
`default_nettype none
package skl_pkg;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned RANK_W       = 7;
  localparam int unsigned MAX_RANK_DEF = 64;

  typedef struct packed {
    logic ins;
    logic load;
  } skl_cmd_t;
endpackage
`default_nettype wire

@@ sv/skl_ctrl.sv @@
// Controller state machine for the k-th largest unit: input handshake and output register valid.
`default_nettype none
module skl_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output skl_pkg::skl_cmd_t    cmd
);
  import skl_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SEL
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign cmd.ins  = (state_r == ST_IDLE) && in_valid;
  assign cmd.load = (state_r == ST_SEL) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_SEL;
          end
        end
        ST_SEL: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

@@ sv/skl_dp.sv @@
// Datapath for the k-th largest unit: sorted insertion cells, count, rank and result register.
`default_nettype none
module skl_dp #(
  parameter int unsigned MAX_RANK = skl_pkg::MAX_RANK_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [skl_pkg::RANK_W-1:0]    cfg_wr_data,
  input  wire skl_pkg::skl_cmd_t             cmd,
  input  wire logic signed [skl_pkg::DATA_W-1:0] in_sample_value,
  output logic signed [skl_pkg::DATA_W-1:0]  out_kth_value,
  output logic                               out_filled
);
  import skl_pkg::*;

  localparam int unsigned CW = $clog2(MAX_RANK + 1);

  logic signed [DATA_W-1:0] cell_r   [MAX_RANK];
  logic signed [DATA_W-1:0] cell_nxt [MAX_RANK];
  logic [CW-1:0]            count_r, count_nxt;
  logic [CW-1:0]            keff_r, keff_nxt;
  logic [MAX_RANK-1:0]      valid;
  logic [MAX_RANK-1:0]      ge;
  logic [MAX_RANK-1:0]      last;
  logic                     drop;
  logic signed [DATA_W-1:0] tail;
  logic signed [DATA_W-1:0] kth_r;
  logic                     filled_r;

  always_comb begin
    if (cfg_wr_data == '0) begin
      keff_nxt = CW'(1);
    end else if (int'(cfg_wr_data) > int'(MAX_RANK)) begin
      keff_nxt = CW'(MAX_RANK);
    end else begin
      keff_nxt = CW'(cfg_wr_data);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_RANK; i++) begin
      valid[i] = (CW'(i) < count_r);
      last[i]  = (CW'(i + 1) == count_r);
      ge[i]    = valid[i] && (cell_r[i] >= in_sample_value);
    end
    // full and the new word is not above the smallest kept one
    drop = (count_r == keff_r) && (|(ge & last));
    cell_nxt[0] = (ge[0] || drop) ? cell_r[0] : in_sample_value;
    for (int i = 1; i < MAX_RANK; i++) begin
      if (ge[i] || drop) begin
        cell_nxt[i] = cell_r[i];
      end else if (ge[i-1]) begin
        cell_nxt[i] = in_sample_value;
      end else begin
        cell_nxt[i] = cell_r[i-1];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cfg_wr_en) begin
      count_nxt = (count_r > keff_nxt) ? keff_nxt : count_r;
    end else if (cmd.ins && (count_r < keff_r)) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_comb begin
    tail = '0;
    for (int i = 0; i < MAX_RANK; i++) begin
      tail = tail | (last[i] ? cell_r[i] : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      keff_r  <= CW'(1);
    end else begin
      count_r <= count_nxt;
      if (cfg_wr_en) begin
        keff_r <= keff_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      for (int i = 0; i < MAX_RANK; i++) begin
        cell_r[i] <= cell_nxt[i];
      end
    end
    if (cmd.load) begin
      kth_r    <= tail;
      filled_r <= (count_r >= keff_r);
    end
  end

  assign out_kth_value = kth_r;
  assign out_filled    = filled_r;
endmodule
`default_nettype wire

@@ sv/streaming_kth_largest_unit.sv @@
// Top level of the streaming k-th largest unit: controller plus insertion-cell datapath.
// Each accepted word is inserted into a row of MAX_RANK sorted cells, all cells comparing
// at once; the select state then loads the smallest kept word into the output register
// once the output is free, and a new word is taken while the previous result still
// waits at the output. out_kth_value is the smallest kept word and
// out_filled is 1 once rank_k words are held. rank_k (written via cfg_wr_en, reset 1,
// 0 acts as 1, above MAX_RANK acts as MAX_RANK) may only change while idle; lowering
// it drops the smallest kept words at once. The cells need no clearing after reset.
`default_nettype none
module streaming_kth_largest_unit #(
  parameter int unsigned MAX_RANK = skl_pkg::MAX_RANK_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [skl_pkg::RANK_W-1:0]        cfg_wr_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [skl_pkg::DATA_W-1:0] in_sample_value,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [skl_pkg::DATA_W-1:0]      out_kth_value,
  output logic                                   out_filled
);
  import skl_pkg::*;

  skl_cmd_t cmd;

  skl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  skl_dp #(
    .MAX_RANK (MAX_RANK)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .cmd             (cmd),
    .in_sample_value (in_sample_value),
    .out_kth_value   (out_kth_value),
    .out_filled      (out_filled)
  );
endmodule
`default_nettype wire

@@ test/tb_streaming_kth_largest_unit.sv @@
// Self-checking testbench for the streaming k-th largest unit: directed table, random phases.
module tb_streaming_kth_largest_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import skl_pkg::*;

  localparam int unsigned RANK_CAP   = MAX_RANK_DEF;
  localparam int          RAND_WORDS = 1530;
  localparam int          CALM_WORDS = 120;
  localparam int          CYCLE_CAP  = 500000;
  localparam logic [31:0] S_MIN      = 32'h8000_0000;
  localparam logic [31:0] S_MAX      = 32'h7FFF_FFFF;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] val;
    logic        typed;
    logic [31:0] want_kth;
    logic        want_filled;
  } dir_row_t;

  typedef struct {
    logic signed [DATA_W-1:0] kth;
    logic                     filled;
  } kth_word_t;

  localparam int DIR_ROWS = 26;

  // after reset rank 1; extremes, rank 0, raise, duplicates, lower, rank above cap
  dir_row_t directed [DIR_ROWS] = '{
    '{ROW_WORD, 32'd0,          1'b1, 32'd0,  1'b1},
    '{ROW_WORD, S_MIN,          1'b1, 32'd0,  1'b1},
    '{ROW_WORD, S_MAX,          1'b1, S_MAX,  1'b1},
    '{ROW_CFG,  32'd0,          1'b0, 32'd0,  1'b0},
    '{ROW_WORD, 32'hFFFF_FFFF,  1'b1, S_MAX,  1'b1},
    '{ROW_CFG,  32'd4,          1'b0, 32'd0,  1'b0},
    '{ROW_WORD, S_MIN,          1'b1, S_MIN,  1'b0},
    '{ROW_WORD, 32'd7,          1'b0, 32'd0,  1'b0},
    '{ROW_WORD, 32'd7,          1'b0, 32'd0,  1'b0},
    '{ROW_WORD, 32'd7,          1'b0, 32'd0,  1'b0},
    '{ROW_WORD, 32'hFFFF_FFFB,  1'b0, 32'd0,  1'b0},
    '{ROW_CFG,  32'd2,          1'b0, 32'd0,  1'b0},
    '{ROW_WORD, S_MIN,          1'b1, 32'd7,  1'b1},
    '{ROW_CFG,  32'd127,        1'b0, 32'd0,  1'b0},
    '{ROW_WORD, 32'd1,          1'b0, 32'd0,  1'b0},
    '{ROW_WORD, 32'h5555_5555,  1'b0, 32'd0,  1'b0},
    '{ROW_WORD, 32'hAAAA_AAAA,  1'b0, 32'd0,  1'b0},
    '{ROW_WORD, 32'hFFFF_FFFF,  1'b0, 32'd0,  1'b0},
    '{ROW_WORD, 32'h8000_0001,  1'b0, 32'd0,  1'b0},
    '{ROW_WORD, 32'h7FFF_FFFE,  1'b0, 32'd0,  1'b0},
    '{ROW_CFG,  32'd64,         1'b0, 32'd0,  1'b0},
    '{ROW_WORD, 32'd3,          1'b0, 32'd0,  1'b0},
    '{ROW_CFG,  32'd65,         1'b0, 32'd0,  1'b0},
    '{ROW_WORD, 32'd2,          1'b0, 32'd0,  1'b0},
    '{ROW_CFG,  32'd1,          1'b0, 32'd0,  1'b0},
    '{ROW_WORD, S_MIN,          1'b1, S_MAX,  1'b1}
  };

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_wr_en;
  logic [RANK_W-1:0]        cfg_wr_data;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [DATA_W-1:0] in_sample_value;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] out_kth_value;
  logic                     out_filled;

  streaming_kth_largest_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_value (in_sample_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kth_value   (out_kth_value),
    .out_filled      (out_filled)
  );

  // predicted store, largest first
  logic signed [DATA_W-1:0] kept [RANK_CAP];
  int unsigned              held;
  logic [RANK_W-1:0]        rank_reg;

  kth_word_t pending_kth [$];
  int        errors;
  int        cycles;
  bit        calm;
  bit        tx_idle_on;
  bit        rx_idle_on;
  int        stall_left;

  function automatic int unsigned eff_rank();
    int unsigned k;
    k = rank_reg;
    if (k < 1) k = 1;
    if (k > RANK_CAP) k = RANK_CAP;
    return k;
  endfunction

  function automatic kth_word_t rank_insert(input logic signed [DATA_W-1:0] v);
    int unsigned k;
    int unsigned pos;
    int unsigned last;
    kth_word_t   r;
    k = eff_rank();
    if (held > k) held = k;
    pos = 0;
    while (pos < held && kept[pos] >= v) pos++;
    if (pos < k) begin
      last = (held < k) ? held : k - 1;
      for (int unsigned i = last; i > pos; i--) kept[i] = kept[i-1];
      kept[pos] = v;
      if (held < k) held++;
    end
    r.kth    = kept[held-1];
    r.filled = (held >= k);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic write_rank(input logic [RANK_W-1:0] r);
    in_valid <= 1'b0;
    while (pending_kth.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= r;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rank_reg = r;
    if (held > eff_rank()) held = eff_rank();
  endtask

  task automatic send_word(input logic signed [DATA_W-1:0] v, input bit typed,
                           input kth_word_t want);
    bit        took;
    kth_word_t pred;
    if (tx_idle_on && !calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_value <= v;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    pred = rank_insert(v);
    if (typed) begin
      pending_kth.insert(pending_kth.size(), want);
    end else begin
      pending_kth.insert(pending_kth.size(), pred);
    end
  endtask

  function automatic logic signed [DATA_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $signed($urandom_range(0, 20)) - 10;
      7: begin
        case ($urandom_range(0, 3))
          0:       return S_MIN;
          1:       return S_MAX;
          2:       return 0;
          default: return -1;
        endcase
      end
      8:       return S_MIN + $urandom_range(0, 3);
      default: return S_MAX - $urandom_range(0, 3);
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("[streaming_kth_largest_unit] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) stall_left--;
    else if (rx_idle_on && !calm && $urandom_range(0, 9) == 0)
      stall_left = $urandom_range(1, 15);
    out_stall <= rst_n && !calm && (stall_left != 0);
  end

  always @(negedge clk) begin
    kth_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_kth.size() == 0) begin
        report_mismatch($sformatf("unexpected word kth=%0d filled=%0b",
                                  out_kth_value, out_filled));
      end else begin
        w = pending_kth.pop_front();
        if (out_kth_value !== w.kth)
          report_mismatch($sformatf("kth_value got %0d want %0d", out_kth_value, w.kth));
        if (out_filled !== w.filled)
          report_mismatch($sformatf("filled got %0b want %0b", out_filled, w.filled));
      end
    end
  end

  initial begin
    kth_word_t   want;
    int          sent;
    int          phase;
    int          n;
    logic [RANK_W-1:0] r;
    errors     = 0;
    cycles     = 0;
    calm       = 1'b0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    stall_left = 0;
    held       = 0;
    rank_reg   = RANK_W'(1);
    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    in_valid        <= 1'b0;
    in_sample_value <= '0;
    out_stall       <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        write_rank(directed[i].val[RANK_W-1:0]);
      end else begin
        want.kth    = $signed(directed[i].want_kth);
        want.filled = directed[i].want_filled;
        send_word($signed(directed[i].val), directed[i].typed, want);
      end
    end

    sent  = 0;
    phase = 0;
    want  = '{default: '0};
    while (sent < RAND_WORDS) begin
      case (phase)
        0: r = RANK_W'(64);
        1: r = RANK_W'(1);
        2: r = RANK_W'(0);
        3: r = RANK_W'(100);
        default: begin
          case ($urandom_range(0, 3))
            0, 1:    r = RANK_W'($urandom_range(1, 8));
            2:       r = RANK_W'($urandom_range(9, 64));
            default: r = RANK_W'($urandom_range(0, 127));
          endcase
        end
      endcase
      write_rank(r);
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(60, 130);
      for (int j = 0; j < n && sent < RAND_WORDS; j++) begin
        calm = (sent >= RAND_WORDS - CALM_WORDS);
        send_word(rand_sample(), 1'b0, want);
        sent++;
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (pending_kth.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("[streaming_kth_largest_unit] OK");
    end else begin
      $display("[streaming_kth_largest_unit] ERROR");
    end
    $finish;
  end
endmodule

@@ streaming_kth_largest_unit.f @@
sv/skl_pkg.sv
sv/skl_ctrl.sv
sv/skl_dp.sv
sv/streaming_kth_largest_unit.sv
test/tb_streaming_kth_largest_unit.sv
